// ----- design/hs3bl_pkg.sv -----
// Shared types and constants for the handshaked three-wire byte link.
// Used by the link core and by its port checker; depends on nothing.

package hs3bl_pkg;

	// Default word length moved per transfer.
	localparam int BITS_PER_WORD_DEF = 8;

	// Configuration register widths and reset values.
	localparam int TMO_W = 24;
	localparam int SETTLE_W = 8;
	localparam logic [TMO_W-1:0] TMO_RST = TMO_W'(500000);
	localparam logic [SETTLE_W-1:0] SETTLE_RST = SETTLE_W'(5);

	// Configuration port geometry.
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	// Width of the shift register; bits sent past it are zero.
	localparam int SHIFT_W = 8;

	typedef enum logic [0:0] {
		REG_TIMEOUT = 1'b0,
		REG_SETTLE  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_SEND = 2'd1,
		REQ_RECV = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	typedef enum logic [9:0] {
		PH_IDLE          = 10'b00_0000_0001,
		PH_S_WAIT_SLOW   = 10'b00_0000_0010,
		PH_S_SETTLE_UP   = 10'b00_0000_0100,
		PH_S_WAIT_SHIGH  = 10'b00_0000_1000,
		PH_S_SETTLE_DOWN = 10'b00_0001_0000,
		PH_S_END_SLOW    = 10'b00_0010_0000,
		PH_S_END_SHIGH   = 10'b00_0100_0000,
		PH_R_WAIT_MHIGH  = 10'b00_1000_0000,
		PH_R_WAIT_MLOW   = 10'b01_0000_0000,
		PH_R_END_MHIGH   = 10'b10_0000_0000
	} phase_t;

	// Driven levels and drive enables of the three lines.
	typedef struct packed {
		logic sda_oe;
		logic sda_out;
		logic sclk_oe;
		logic sclk_out;
		logic mclk_oe;
		logic mclk_out;
	} lines_t;

	localparam lines_t LINES_RELEASED = '{
		sda_oe: 1'b0, sda_out: 1'b1,
		sclk_oe: 1'b0, sclk_out: 1'b1,
		mclk_oe: 1'b0, mclk_out: 1'b1
	};

	// One tick as it arrives on the input stream (tuser carries req_type).
	typedef struct packed {
		logic       sda_in;
		logic       sclk_in;
		logic       mclk_in;
		logic [7:0] send_byte;
	} in_t;

	// One result as it leaves on the output stream.
	typedef struct packed {
		logic [7:0] rx_byte;
		status_t    status;
		logic       done_res;
		logic       busy_res;
		lines_t     lines;
	} res_t;

	localparam int IN_W = $bits(in_t);
	localparam int RES_W = $bits(res_t);
	localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
	localparam int S_TUSER_W = $bits(req_t);

endpackage

// ----- design/handshake_three_wire_byte_link_core.sv -----
// Handshaked three-wire byte link: one input transaction per clock tick.
// Each input transaction passes the input register, then the result register, on its way to its result.
// Throughput: one transaction per cycle while results are taken; a stalled result stops intake
// once the input register also holds a transaction.
// Reset (arst_n low, asynchronous): link idle, all lines released, registers at defaults.
// Depends on hs3bl_pkg for types and constants.

module handshake_three_wire_byte_link_core #(
	parameter int BITS_PER_WORD = hs3bl_pkg::BITS_PER_WORD_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input stream. tdata from bit 0: send_byte[7:0], mclk_in, sclk_in, sda_in, zero fill.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [hs3bl_pkg::S_TDATA_W-1:0] s_tdata,
	// tuser from bit 0: req_type[1:0].
	input  logic [hs3bl_pkg::S_TUSER_W-1:0] s_tuser,
	// Output stream. tdata from bit 0: mclk_out, mclk_oe, sclk_out, sclk_oe, sda_out,
	// sda_oe, busy_res, done_res, status[1:0], rx_byte[7:0], zero fill.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hs3bl_pkg::M_TDATA_W-1:0] m_tdata,
	// Configuration port.
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [hs3bl_pkg::CFG_AW-1:0]    paddr,
	input  logic [hs3bl_pkg::CFG_DW-1:0]    pwdata,
	output logic [hs3bl_pkg::CFG_DW-1:0]    prdata,
	output logic                            pready
);

	// The bit counter has to hold the full word length.
	localparam int BC_W = $clog2(BITS_PER_WORD + 1);

	// ------------------------------------------------------------------
	// Configuration registers. Writes complete in the access cycle; the
	// register index is taken from the word address bit.
	// ------------------------------------------------------------------
	logic [hs3bl_pkg::TMO_W-1:0]    tmo_q;
	logic [hs3bl_pkg::SETTLE_W-1:0] settle_cfg_q;
	logic                           cfg_we;
	hs3bl_pkg::reg_idx_t            cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = hs3bl_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_q        <= hs3bl_pkg::TMO_RST;
			settle_cfg_q <= hs3bl_pkg::SETTLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				hs3bl_pkg::REG_TIMEOUT: tmo_q <= pwdata[hs3bl_pkg::TMO_W-1:0];
				hs3bl_pkg::REG_SETTLE:  settle_cfg_q <= pwdata[hs3bl_pkg::SETTLE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			hs3bl_pkg::REG_TIMEOUT:
				prdata = hs3bl_pkg::CFG_DW'(tmo_q);
			hs3bl_pkg::REG_SETTLE:
				prdata = hs3bl_pkg::CFG_DW'(settle_cfg_q);
		endcase
	end

	// ------------------------------------------------------------------
	// Input register. It accepts a new transaction whenever it is empty
	// or its current content moves on into the result register in the
	// same cycle, so intake never waits for the link state machine.
	// ------------------------------------------------------------------
	logic               vld_s1;
	hs3bl_pkg::in_t     in_s1;
	logic [1:0]         req_s1;
	logic               out_vld_q;
	hs3bl_pkg::res_t    res_q;
	logic               adv;
	logic               fire;

	assign adv      = !out_vld_q || m_tready;
	assign fire     = vld_s1 && adv;
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_s1  <= hs3bl_pkg::in_t'(s_tdata[hs3bl_pkg::IN_W-1:0]);
			req_s1 <= s_tuser;
		end
	end

	// ------------------------------------------------------------------
	// Link state. Every tick in the input register is applied to this
	// state in the cycle it moves to the result register.
	// ------------------------------------------------------------------
	hs3bl_pkg::phase_t              phase_q, phase_d;
	logic [BC_W-1:0]                bc_q, bc_d;
	logic [hs3bl_pkg::SHIFT_W-1:0]  shift_q, shift_d;
	logic [hs3bl_pkg::TMO_W-1:0]    wait_q, wait_d;
	logic [hs3bl_pkg::SETTLE_W-1:0] settle_q, settle_d;
	hs3bl_pkg::lines_t              lines_q, lines_d;
	hs3bl_pkg::res_t                res_d;

	logic is_wait;
	logic cond;
	logic mclk;
	logic sclk;

	assign mclk = in_s1.mclk_in;
	assign sclk = in_s1.sclk_in;

	// Which phases wait on a partner edge, and what each one waits for.
	always_comb begin
		is_wait = 1'b1;
		cond    = 1'b0;
		unique case (phase_q)
			hs3bl_pkg::PH_S_WAIT_SLOW,
			hs3bl_pkg::PH_S_END_SLOW:   cond = !sclk;
			hs3bl_pkg::PH_S_WAIT_SHIGH,
			hs3bl_pkg::PH_S_END_SHIGH:  cond = sclk;
			hs3bl_pkg::PH_R_WAIT_MHIGH,
			hs3bl_pkg::PH_R_END_MHIGH:  cond = mclk;
			hs3bl_pkg::PH_R_WAIT_MLOW:  cond = !mclk;
			default:                    is_wait = 1'b0;
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		bc_d     = bc_q;
		shift_d  = shift_q;
		wait_d   = wait_q;
		settle_d = settle_q;
		lines_d  = lines_q;
		res_d    = '0;
		res_d.status = hs3bl_pkg::ST_OK;

		unique case (phase_q)
			hs3bl_pkg::PH_IDLE: begin
				case (req_s1)
					hs3bl_pkg::REQ_SEND: begin
						if (!mclk) begin
							res_d.done_res = 1'b1;
							res_d.status   = hs3bl_pkg::ST_REFUSED;
						end else begin
							lines_d.mclk_oe  = 1'b1;
							lines_d.sda_oe   = 1'b1;
							lines_d.mclk_out = 1'b0;
							shift_d = in_s1.send_byte;
							bc_d    = BC_W'(BITS_PER_WORD);
							wait_d  = tmo_q;
							phase_d = hs3bl_pkg::PH_S_WAIT_SLOW;
						end
					end
					hs3bl_pkg::REQ_RECV: begin
						if (mclk) begin
							res_d.done_res = 1'b1;
							res_d.status   = hs3bl_pkg::ST_REFUSED;
						end else begin
							lines_d.sclk_oe  = 1'b1;
							lines_d.sclk_out = 1'b0;
							shift_d = '0;
							bc_d    = BC_W'(BITS_PER_WORD);
							wait_d  = tmo_q;
							phase_d = hs3bl_pkg::PH_R_WAIT_MHIGH;
						end
					end
					default: begin
						// Plain tick: nothing to start.
					end
				endcase
			end
			hs3bl_pkg::PH_S_WAIT_SLOW: begin
				if (cond) begin
					lines_d.sda_out = shift_q[0];
					settle_d = settle_cfg_q;
					phase_d  = hs3bl_pkg::PH_S_SETTLE_UP;
				end
			end
			hs3bl_pkg::PH_S_SETTLE_UP: begin
				if (settle_q == '0) begin
					lines_d.mclk_out = 1'b1;
					shift_d = shift_q >> 1;
					if (bc_q != '0) begin
						bc_d = bc_q - BC_W'(1);
					end
					wait_d  = tmo_q;
					phase_d = hs3bl_pkg::PH_S_WAIT_SHIGH;
				end else begin
					settle_d = settle_q - hs3bl_pkg::SETTLE_W'(1);
				end
			end
			hs3bl_pkg::PH_S_WAIT_SHIGH: begin
				if (cond) begin
					settle_d = settle_cfg_q;
					phase_d  = hs3bl_pkg::PH_S_SETTLE_DOWN;
				end
			end
			hs3bl_pkg::PH_S_SETTLE_DOWN: begin
				if (settle_q == '0) begin
					lines_d.mclk_out = 1'b0;
					wait_d  = tmo_q;
					phase_d = (bc_q == '0) ? hs3bl_pkg::PH_S_END_SLOW
					                       : hs3bl_pkg::PH_S_WAIT_SLOW;
				end else begin
					settle_d = settle_q - hs3bl_pkg::SETTLE_W'(1);
				end
			end
			hs3bl_pkg::PH_S_END_SLOW: begin
				if (cond) begin
					lines_d.mclk_out = 1'b1;
					lines_d.mclk_oe  = 1'b0;
					wait_d  = tmo_q;
					phase_d = hs3bl_pkg::PH_S_END_SHIGH;
				end
			end
			hs3bl_pkg::PH_S_END_SHIGH: begin
				if (cond) begin
					lines_d.sda_oe = 1'b0;
					res_d.done_res = 1'b1;
					phase_d = hs3bl_pkg::PH_IDLE;
				end
			end
			hs3bl_pkg::PH_R_WAIT_MHIGH: begin
				if (cond) begin
					shift_d = {in_s1.sda_in, shift_q[hs3bl_pkg::SHIFT_W-1:1]};
					lines_d.sclk_out = 1'b1;
					wait_d  = tmo_q;
					phase_d = hs3bl_pkg::PH_R_WAIT_MLOW;
				end
			end
			hs3bl_pkg::PH_R_WAIT_MLOW: begin
				if (cond) begin
					lines_d.sclk_out = 1'b0;
					if (bc_q != '0) begin
						bc_d = bc_q - BC_W'(1);
					end
					wait_d  = tmo_q;
					phase_d = (bc_d == '0) ? hs3bl_pkg::PH_R_END_MHIGH
					                       : hs3bl_pkg::PH_R_WAIT_MHIGH;
				end
			end
			hs3bl_pkg::PH_R_END_MHIGH: begin
				if (cond) begin
					lines_d.sclk_out = 1'b1;
					lines_d.sclk_oe  = 1'b0;
					res_d.rx_byte  = shift_q;
					res_d.done_res = 1'b1;
					phase_d = hs3bl_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = hs3bl_pkg::PH_IDLE;
			end
		endcase

		// Unmet wait: count down, and abort once the budget is spent.
		// A limit of zero behaves like one because both end on the first miss.
		if (is_wait && !cond) begin
			if (wait_q[hs3bl_pkg::TMO_W-1:1] == '0) begin
				wait_d         = '0;
				lines_d        = hs3bl_pkg::LINES_RELEASED;
				res_d.done_res = 1'b1;
				res_d.status   = hs3bl_pkg::ST_TIMEOUT;
				phase_d        = hs3bl_pkg::PH_IDLE;
			end else begin
				wait_d = wait_q - hs3bl_pkg::TMO_W'(1);
			end
		end

		res_d.lines    = lines_d;
		res_d.busy_res = (phase_d != hs3bl_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hs3bl_pkg::PH_IDLE;
			bc_q     <= '0;
			shift_q  <= '0;
			wait_q   <= '0;
			settle_q <= '0;
			lines_q  <= hs3bl_pkg::LINES_RELEASED;
		end else if (fire) begin
			phase_q  <= phase_d;
			bc_q     <= bc_d;
			shift_q  <= shift_d;
			wait_q   <= wait_d;
			settle_q <= settle_d;
			lines_q  <= lines_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register. It holds a result until the consumer takes it.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = hs3bl_pkg::M_TDATA_W'(res_q);

endmodule

// ----- design/hs3bl_checker.sv -----
// Port-level checker for the handshaked three-wire byte link core.
// Depends on hs3bl_pkg; bound to handshake_three_wire_byte_link_core below.

module hs3bl_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [hs3bl_pkg::M_TDATA_W-1:0] m_tdata
);

	hs3bl_pkg::res_t res;

	assign res = hs3bl_pkg::res_t'(m_tdata[hs3bl_pkg::RES_W-1:0]);

	// A stalled result keeps its place and its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output result changed while stalled");

	// With the output side empty, intake must be open.
	a_intake_open: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output");

	// A finished transfer leaves the link idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.done_res |-> !res.busy_res)
		else $error("done reported while still busy");

	// Status and received byte only carry meaning with done.
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.done_res |-> res.status == hs3bl_pkg::ST_OK && res.rx_byte == '0)
		else $error("status or byte reported without done");

	// A timeout releases every line.
	a_timeout_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.done_res && res.status == hs3bl_pkg::ST_TIMEOUT
			|-> res.lines == hs3bl_pkg::LINES_RELEASED)
		else $error("lines still driven after a timeout");

endmodule

bind handshake_three_wire_byte_link_core hs3bl_checker u_hs3bl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
